// ===== design/first_fit_slot_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// first_fit_slot_allocator_top_assert.svh
// Assertion macros used by the allocator controller.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_SLOT_ALLOCATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define FFSA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ffsa assertion failed");
`define FFSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffsa sequence assertion failed");
`else
`define FFSA_ASSERT(lbl, clk, rst, prop)
`define FFSA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== design/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg
// Widths, codes and control/status types of the first-fit slot allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

   localparam int SLOTS_PER_SECTION = 4096;
   localparam int NUM_SECTIONS      = 4;
   localparam int MAX_RUN           = 8;

   localparam int CMD_W   = 3;
   localparam int SEC_W   = $clog2(NUM_SECTIONS);
   localparam int ADDR_W  = $clog2(SLOTS_PER_SECTION);
   localparam int SIZE_W  = $clog2(SLOTS_PER_SECTION + 1);
   localparam int LEN_W   = $clog2(MAX_RUN + 1);
   localparam int OFS_W   = $clog2(MAX_RUN);
   localparam int ID_W    = 16;
   localparam int TAG_W   = 16;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = LEN_W;

   // One memory row holds MAX_RUN slots, so a run touches at most two rows.
   localparam int ROW_SLOTS = MAX_RUN;
   localparam int ROWS_PER_SEC = SLOTS_PER_SECTION / ROW_SLOTS;
   localparam int RIS_W    = $clog2(ROWS_PER_SEC);
   localparam int TOT_ROWS = ROWS_PER_SEC * NUM_SECTIONS;
   localparam int ROW_AW   = $clog2(TOT_ROWS);
   localparam int OWN_ROW_W = ID_W * ROW_SLOTS;
   localparam int TAG_ROW_W = TAG_W * ROW_SLOTS;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FREE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_MARK  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADADDR = 2'd2;
   localparam logic [STAT_W-1:0] ST_MIXED   = 2'd3;

   localparam logic [1:0] RS_CLR  = 2'd0;
   localparam logic [1:0] RS_SCAN = 2'd1;
   localparam logic [1:0] RS_A    = 2'd2;
   localparam logic [1:0] RS_B    = 2'd3;

   typedef struct packed {
      logic              capture;
      logic              clr_step;
      logic              reload;
      logic              scan_start;
      logic              scan_step;
      logic              latch_a;
      logic              latch_b;
      logic              exec;
      logic              commit;
      logic              load_rsp;
      logic              wr_own;
      logic              wr_tag;
      logic              set_stat;
      logic [STAT_W-1:0] stat_code;
      logic [1:0]        ram_sel;
   } ctl_type;

   typedef struct packed {
      logic is_clear;
      logic bad;
      logic nospace;
      logic is_alloc;
      logic scan_hit;
      logic scan_miss;
      logic skip_write;
      logic clr_last;
   } sts_type;

   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
      return (r > SIZE_W'(SLOTS_PER_SECTION)) ? SIZE_W'(SLOTS_PER_SECTION) : r;
   endfunction

endpackage

// ===== design/ffsa_ram.sv =====
// ----------------------------------------------------------------------------
// ffsa_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ffsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/ffsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer of the allocator: clearing pass, decode, scan, read-modify-write.
// ----------------------------------------------------------------------------
`include "first_fit_slot_allocator_top_assert.svh"

module ffsa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ffsa_pkg::sts_type sts,
   output ffsa_pkg::ctl_type ctl
);
   import ffsa_pkg::*;

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DEC  = 4'd2;
   localparam logic [3:0] S_SCAN = 4'd3;
   localparam logic [3:0] S_RDA  = 4'd4;
   localparam logic [3:0] S_RDB  = 4'd5;
   localparam logic [3:0] S_LAT  = 4'd6;
   localparam logic [3:0] S_EXEC = 4'd7;
   localparam logic [3:0] S_WRA  = 4'd8;
   localparam logic [3:0] S_WRB  = 4'd9;
   localparam logic [3:0] S_RESP = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       clr_cmd_ff, clr_cmd_in;
   logic       rsp_valid_ff;

   always_comb begin
      ctl        = '0;
      state_in   = state_ff;
      clr_cmd_in = clr_cmd_ff;
      case (state_ff)
         S_CLR: begin
            ctl.ram_sel  = RS_CLR;
            ctl.wr_own   = 1'b1;
            ctl.clr_step = 1'b1;
            if (sts.clr_last) begin
               clr_cmd_in = 1'b0;
               if (clr_cmd_ff) begin
                  ctl.reload = 1'b1;
                  state_in   = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DEC;
            end
         end
         S_DEC: begin
            if (sts.is_clear) begin
               clr_cmd_in = 1'b1;
               state_in   = S_CLR;
            end else if (sts.bad) begin
               ctl.set_stat  = 1'b1;
               ctl.stat_code = ST_BADADDR;
               state_in      = S_RESP;
            end else if (sts.nospace) begin
               ctl.set_stat  = 1'b1;
               ctl.stat_code = ST_NOSPACE;
               state_in      = S_RESP;
            end else if (sts.is_alloc) begin
               ctl.scan_start = 1'b1;
               state_in       = S_SCAN;
            end else begin
               state_in = S_RDA;
            end
         end
         S_SCAN: begin
            ctl.ram_sel   = RS_SCAN;
            ctl.scan_step = 1'b1;
            if (sts.scan_hit) begin
               state_in = S_RDA;
            end else if (sts.scan_miss) begin
               ctl.set_stat  = 1'b1;
               ctl.stat_code = ST_NOSPACE;
               state_in      = S_RESP;
            end
         end
         S_RDA: begin
            ctl.ram_sel = RS_A;
            state_in    = S_RDB;
         end
         S_RDB: begin
            ctl.ram_sel = RS_B;
            ctl.latch_a = 1'b1;
            state_in    = S_LAT;
         end
         S_LAT: begin
            ctl.latch_b = 1'b1;
            state_in    = S_EXEC;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = sts.skip_write ? S_RESP : S_WRA;
         end
         S_WRA: begin
            ctl.ram_sel = RS_A;
            ctl.wr_own  = 1'b1;
            ctl.wr_tag  = 1'b1;
            state_in    = S_WRB;
         end
         S_WRB: begin
            ctl.ram_sel = RS_B;
            ctl.wr_own  = 1'b1;
            ctl.wr_tag  = 1'b1;
            ctl.commit  = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cmd_ff <= clr_cmd_in;
         if (ctl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `FFSA_ASSERT(a_hit_miss_excl, clock, reset, !(sts.scan_hit && sts.scan_miss))
   `FFSA_ASSERT_NEXT(a_accept_decode, clock, reset, req_valid && req_ready, state_ff == S_DEC)
   `FFSA_ASSERT_NEXT(a_resp_load, clock, reset, state_ff == S_RESP && !rsp_valid_ff, rsp_valid_ff)
   `FFSA_ASSERT(a_idle_no_write, clock, reset, !(state_ff == S_IDLE && (ctl.wr_own || ctl.wr_tag)))
endmodule

// ===== design/ffsa_datapath.sv =====
// ----------------------------------------------------------------------------
// ffsa_datapath
// Request and size registers, free counts, slot memories, scan and run logic.
// ----------------------------------------------------------------------------
module ffsa_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ffsa_pkg::ctl_type             ctl,
   output ffsa_pkg::sts_type             sts,
   input  logic [ffsa_pkg::CMD_W-1:0]    req_command,
   input  logic [ffsa_pkg::SEC_W-1:0]    req_section,
   input  logic [ffsa_pkg::ADDR_W-1:0]   req_slot_address,
   input  logic [ffsa_pkg::LEN_W-1:0]    req_run_length,
   input  logic [ffsa_pkg::ID_W-1:0]     req_owner_id,
   input  logic [ffsa_pkg::TAG_W-1:0]    req_tag,
   input  logic                          req_charge,
   input  logic                          csr_write,
   input  logic [ffsa_pkg::SEC_W-1:0]    csr_index,
   input  logic [ffsa_pkg::SIZE_W-1:0]   csr_wdata,
   output logic [ffsa_pkg::STAT_W-1:0]   rsp_status,
   output logic [ffsa_pkg::ADDR_W-1:0]   rsp_found_address,
   output logic [ffsa_pkg::ID_W-1:0]     rsp_found_owner,
   output logic [ffsa_pkg::TAG_W-1:0]    rsp_found_tag,
   output logic [ffsa_pkg::CNT_W-1:0]    rsp_owned_count,
   output logic [ffsa_pkg::SIZE_W-1:0]   rsp_free_count
);
   import ffsa_pkg::*;

   logic [CMD_W-1:0]  cmd_ff;
   logic [SEC_W-1:0]  sec_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [ID_W-1:0]   owner_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic              charge_ff;

   logic [SIZE_W-1:0] size_ff [NUM_SECTIONS];
   logic [SIZE_W-1:0] free_ff [NUM_SECTIONS];

   logic [SIZE_W-1:0] eff, eff_m1, free_cur, end_sum;
   logic [RIS_W-1:0]  last_row;
   logic              run_over;

   logic [ROW_AW-1:0] clr_row_ff;
   logic [RIS_W-1:0]  scan_rd_ff, chk_row_ff;
   logic              scan_iss_ff, chk_vld_ff;
   logic [LEN_W-1:0]  run_len_ff, rl_out;
   logic [ADDR_W-1:0] run_st_ff, st_out, hit_st;
   logic              hit;

   logic [OWN_ROW_W-1:0] own_a_ff, own_b_ff, own_rd, own_wd;
   logic [TAG_ROW_W-1:0] tag_a_ff, tag_b_ff, tag_rd, tag_wd;
   logic [2*OWN_ROW_W-1:0] win_own, win_own_sh, new_own;
   logic [2*TAG_ROW_W-1:0] win_tag, win_tag_sh, new_tag;
   logic [OWN_ROW_W-1:0] run_own;
   logic [TAG_ROW_W-1:0] run_tag;
   logic [OFS_W-1:0]     ofs;
   logic [ROW_AW-1:0]    row_a, ram_addr;
   logic [ID_W-1:0]      wr_owner;

   logic [ID_W-1:0]  q_owner;
   logic [TAG_W-1:0] q_tag;
   logic [CNT_W-1:0] q_cnt;
   logic             mixed;

   logic [STAT_W-1:0] res_status_ff;
   logic [ADDR_W-1:0] res_faddr_ff;
   logic [ID_W-1:0]   res_owner_ff;
   logic [TAG_W-1:0]  res_tag_ff;
   logic [CNT_W-1:0]  res_cnt_ff;
   logic [SIZE_W:0]   free_sum;

   // Decode of the held request.
   assign eff      = eff_size(size_ff[sec_ff]);
   assign eff_m1   = eff - SIZE_W'(1);
   assign last_row = eff_m1[ADDR_W-1:OFS_W];
   assign free_cur = free_ff[sec_ff];
   assign end_sum  = {1'b0, addr_ff} + SIZE_W'(len_ff);
   assign run_over = end_sum > eff;

   assign sts.is_clear = (cmd_ff == CMD_CLEAR);
   assign sts.is_alloc = (cmd_ff == CMD_ALLOC);
   assign sts.bad = (cmd_ff > CMD_QUERY) || (len_ff == '0)
                 || (len_ff > LEN_W'(MAX_RUN))
                 || ((cmd_ff == CMD_ALLOC) && (owner_ff == '0))
                 || (((cmd_ff == CMD_FREE) || (cmd_ff == CMD_MARK)) && run_over)
                 || ((cmd_ff == CMD_QUERY) && ({1'b0, addr_ff} >= eff));
   assign sts.nospace = (cmd_ff == CMD_ALLOC)
                     && ((free_cur < SIZE_W'(len_ff)) || (eff < SIZE_W'(len_ff)));
   assign sts.clr_last = (clr_row_ff == ROW_AW'(TOT_ROWS - 1));

   // First-fit walk over the eight slots of one row.
   always_comb begin
      logic [ADDR_W-1:0] idx;
      logic              fr;
      rl_out = run_len_ff;
      st_out = run_st_ff;
      hit    = 1'b0;
      hit_st = run_st_ff;
      for (int k = 0; k < ROW_SLOTS; k++) begin
         idx = {chk_row_ff, OFS_W'(k)};
         fr  = (own_rd[k*ID_W +: ID_W] == '0) && ({1'b0, idx} < eff);
         if (!hit) begin
            if (fr) begin
               if (rl_out == '0) begin
                  st_out = idx;
               end
               rl_out = rl_out + LEN_W'(1);
               if (rl_out == len_ff) begin
                  hit    = 1'b1;
                  hit_st = st_out;
               end
            end else begin
               rl_out = '0;
            end
         end
      end
   end

   assign sts.scan_hit  = chk_vld_ff && hit;
   assign sts.scan_miss = chk_vld_ff && !hit && (chk_row_ff == last_row);

   // Two-row window around the run.
   assign ofs        = addr_ff[OFS_W-1:0];
   assign row_a      = {sec_ff, addr_ff[ADDR_W-1:OFS_W]};
   assign win_own    = {own_b_ff, own_a_ff};
   assign win_tag    = {tag_b_ff, tag_a_ff};
   assign win_own_sh = win_own >> (ID_W * int'(ofs));
   assign win_tag_sh = win_tag >> (TAG_W * int'(ofs));
   assign run_own    = win_own_sh[OWN_ROW_W-1:0];
   assign run_tag    = win_tag_sh[TAG_ROW_W-1:0];
   assign wr_owner   = (cmd_ff == CMD_FREE) ? '0 : owner_ff;

   always_comb begin
      logic [ID_W-1:0] o;
      logic            inr;
      q_owner = '0;
      q_tag   = '0;
      q_cnt   = '0;
      mixed   = 1'b0;
      for (int j = 0; j < ROW_SLOTS; j++) begin
         o   = run_own[j*ID_W +: ID_W];
         inr = (j < int'(len_ff)) && ((int'(addr_ff) + j) < int'(eff));
         if (inr && (o != '0)) begin
            q_cnt = q_cnt + CNT_W'(1);
            if (q_owner == '0) begin
               q_owner = o;
               q_tag   = run_tag[j*TAG_W +: TAG_W];
            end
         end
         if ((j >= 1) && (j < int'(len_ff)) && (o != run_own[ID_W-1:0])) begin
            mixed = 1'b1;
         end
      end
   end

   assign sts.skip_write = (cmd_ff == CMD_QUERY) || ((cmd_ff == CMD_FREE) && mixed);

   always_comb begin
      logic inrun;
      for (int m = 0; m < 2 * ROW_SLOTS; m++) begin
         inrun = (m >= int'(ofs)) && (m < int'(ofs) + int'(len_ff));
         new_own[m*ID_W +: ID_W] = inrun ? wr_owner : win_own[m*ID_W +: ID_W];
         new_tag[m*TAG_W +: TAG_W] = (inrun && (cmd_ff != CMD_FREE))
                                   ? tag_ff : win_tag[m*TAG_W +: TAG_W];
      end
   end

   always_comb begin
      case (ctl.ram_sel)
         RS_CLR: begin
            ram_addr = clr_row_ff;
            own_wd   = '0;
            tag_wd   = '0;
         end
         RS_SCAN: begin
            ram_addr = {sec_ff, scan_rd_ff};
            own_wd   = '0;
            tag_wd   = '0;
         end
         RS_A: begin
            ram_addr = row_a;
            own_wd   = new_own[OWN_ROW_W-1:0];
            tag_wd   = new_tag[TAG_ROW_W-1:0];
         end
         RS_B: begin
            ram_addr = row_a + ROW_AW'(1);
            own_wd   = new_own[2*OWN_ROW_W-1:OWN_ROW_W];
            tag_wd   = new_tag[2*TAG_ROW_W-1:TAG_ROW_W];
         end
         default: begin
            ram_addr = row_a;
            own_wd   = '0;
            tag_wd   = '0;
         end
      endcase
   end

   ffsa_ram #(.WIDTH(OWN_ROW_W), .DEPTH(TOT_ROWS)) u_owner_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ctl.wr_own),
      .wdata (own_wd),
      .rdata (own_rd)
   );

   ffsa_ram #(.WIDTH(TAG_ROW_W), .DEPTH(TOT_ROWS)) u_tag_ram (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ctl.wr_tag),
      .wdata (tag_wd),
      .rdata (tag_rd)
   );

   // Request and window registers.
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff    <= req_command;
         sec_ff    <= req_section;
         addr_ff   <= req_slot_address;
         len_ff    <= req_run_length;
         owner_ff  <= req_owner_id;
         tag_ff    <= req_tag;
         charge_ff <= req_charge;
      end else if (ctl.scan_step && sts.scan_hit) begin
         addr_ff <= hit_st;
      end
      if (ctl.latch_a) begin
         own_a_ff <= own_rd;
         tag_a_ff <= tag_rd;
      end
      if (ctl.latch_b) begin
         own_b_ff <= own_rd;
         tag_b_ff <= tag_rd;
      end
      if (ctl.scan_step && chk_vld_ff) begin
         run_len_ff <= rl_out;
         run_st_ff  <= st_out;
      end else if (ctl.scan_start) begin
         run_len_ff <= '0;
      end
      if (ctl.scan_step) begin
         chk_row_ff <= scan_rd_ff;
      end
   end

   // Scan and clear counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_row_ff  <= '0;
         scan_rd_ff  <= '0;
         scan_iss_ff <= 1'b0;
         chk_vld_ff  <= 1'b0;
      end else begin
         if (ctl.clr_step) begin
            clr_row_ff <= clr_row_ff + ROW_AW'(1);
         end
         if (ctl.scan_start) begin
            scan_rd_ff  <= '0;
            scan_iss_ff <= 1'b1;
            chk_vld_ff  <= 1'b0;
         end else if (ctl.scan_step) begin
            chk_vld_ff <= scan_iss_ff;
            if (scan_iss_ff) begin
               scan_rd_ff <= scan_rd_ff + RIS_W'(1);
               if (scan_rd_ff == last_row) begin
                  scan_iss_ff <= 1'b0;
               end
            end
         end
      end
   end

   // Section sizes and free counts.
   assign free_sum = {1'b0, free_cur} + (SIZE_W + 1)'(len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SECTIONS; i++) begin
            size_ff[i] <= SIZE_W'(SLOTS_PER_SECTION);
            free_ff[i] <= SIZE_W'(SLOTS_PER_SECTION);
         end
      end else begin
         if (csr_write) begin
            size_ff[csr_index] <= csr_wdata;
         end
         if (ctl.reload) begin
            for (int i = 0; i < NUM_SECTIONS; i++) begin
               free_ff[i] <= eff_size(size_ff[i]);
            end
         end else if (ctl.commit) begin
            case (cmd_ff)
               CMD_FREE: begin
                  free_ff[sec_ff] <= (free_sum > {1'b0, eff}) ? eff : free_sum[SIZE_W-1:0];
               end
               CMD_MARK: begin
                  if (charge_ff) begin
                     free_ff[sec_ff] <= (free_cur > SIZE_W'(len_ff))
                                      ? free_cur - SIZE_W'(len_ff) : '0;
                  end
               end
               CMD_ALLOC: begin
                  free_ff[sec_ff] <= free_cur - SIZE_W'(len_ff);
               end
               default: begin
                  free_ff[sec_ff] <= free_cur;
               end
            endcase
         end
      end
   end

   // Result and response registers.
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         res_status_ff <= ST_OK;
         res_faddr_ff  <= '0;
         res_owner_ff  <= '0;
         res_tag_ff    <= '0;
         res_cnt_ff    <= '0;
      end else if (ctl.set_stat) begin
         res_status_ff <= ctl.stat_code;
      end else if (ctl.exec) begin
         if (cmd_ff == CMD_QUERY) begin
            res_owner_ff <= q_owner;
            res_tag_ff   <= q_tag;
            res_cnt_ff   <= q_cnt;
         end
         if (cmd_ff == CMD_ALLOC) begin
            res_faddr_ff <= addr_ff;
         end
         if ((cmd_ff == CMD_FREE) && mixed) begin
            res_status_ff <= ST_MIXED;
         end
      end
      if (ctl.load_rsp) begin
         rsp_status        <= res_status_ff;
         rsp_found_address <= res_faddr_ff;
         rsp_found_owner   <= res_owner_ff;
         rsp_found_tag     <= res_tag_ff;
         rsp_owned_count   <= res_cnt_ff;
         rsp_free_count    <= free_ff[sec_ff];
      end
   end
endmodule

// ===== design/first_fit_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_slot_allocator_top
// First-fit allocator of contiguous slot runs over four sections.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready, one at a time; each request yields
// exactly one response on rsp_valid/rsp_ready, held in an output register.
// Section sizes are written over the csr_ port, which is always ready; a new
// size takes effect for free counts at the next clear.
// Steps from request acceptance to rsp_valid:
//   rejected request: decode, then the response state;
//   free, mark: two row reads, one update, two row writes;
//   query, or a free that finds a mixed run: no row writes;
//   allocate: a walk over the rows of the section, then the steps of a
//   free; the first-fit walk reads one row of eight slots per cycle from
//   the owner memory;
//   clear: one owner-memory row cleared per cycle.
// After reset the owner memory is swept the same way, and req_ready stays
// low during the sweep. A request is taken again as soon as the block
// is idle, even while the previous response still waits; if the receiver
// stalls, the next response waits in the final state until the output
// register is free.
// ----------------------------------------------------------------------------
module first_fit_slot_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ffsa_pkg::CMD_W-1:0]    req_command,
   input  logic [ffsa_pkg::SEC_W-1:0]    req_section,
   input  logic [ffsa_pkg::ADDR_W-1:0]   req_slot_address,
   input  logic [ffsa_pkg::LEN_W-1:0]    req_run_length,
   input  logic [ffsa_pkg::ID_W-1:0]     req_owner_id,
   input  logic [ffsa_pkg::TAG_W-1:0]    req_tag,
   input  logic                          req_charge,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffsa_pkg::STAT_W-1:0]   rsp_status,
   output logic [ffsa_pkg::ADDR_W-1:0]   rsp_found_address,
   output logic [ffsa_pkg::ID_W-1:0]     rsp_found_owner,
   output logic [ffsa_pkg::TAG_W-1:0]    rsp_found_tag,
   output logic [ffsa_pkg::CNT_W-1:0]    rsp_owned_count,
   output logic [ffsa_pkg::SIZE_W-1:0]   rsp_free_count,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ffsa_pkg::SEC_W-1:0]    csr_index,
   input  logic [ffsa_pkg::SIZE_W-1:0]   csr_wdata
);
   import ffsa_pkg::*;

   ctl_type ctl;
   sts_type sts;

   assign csr_ready = 1'b1;

   ffsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   ffsa_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .sts               (sts),
      .req_command       (req_command),
      .req_section       (req_section),
      .req_slot_address  (req_slot_address),
      .req_run_length    (req_run_length),
      .req_owner_id      (req_owner_id),
      .req_tag           (req_tag),
      .req_charge        (req_charge),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_status        (rsp_status),
      .rsp_found_address (rsp_found_address),
      .rsp_found_owner   (rsp_found_owner),
      .rsp_found_tag     (rsp_found_tag),
      .rsp_owned_count   (rsp_owned_count),
      .rsp_free_count    (rsp_free_count)
   );
endmodule

// ===== verif/tb_first_fit_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_slot_allocator_top
// Self-checking testbench of the first-fit slot allocator.
// ----------------------------------------------------------------------------
// A driver sends requests from a pending queue with random gaps. A monitor
// accepts responses with random stalls. Every accepted request is run
// through a behavioral copy of the ownership map, and the expected response
// is compared field by field with the next response. Section sizes change
// between phases, each phase starting from a clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_first_fit_slot_allocator_top;
   import ffsa_pkg::*;

   localparam int TOTAL = NUM_SECTIONS * SLOTS_PER_SECTION;
   localparam int CYCLE_LIMIT = 10000000;

   // Command codes that the block does not define.
   localparam logic [CMD_W-1:0] CMD_UNUSED_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [SEC_W-1:0]  sec;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      logic [ID_W-1:0]   owner;
      logic [TAG_W-1:0]  tag;
      logic              charge;
   } alloc_req_t;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [ADDR_W-1:0] addr;
      logic [ID_W-1:0]   owner;
      logic [TAG_W-1:0]  tag;
      logic [CNT_W-1:0]  owned;
      logic [SIZE_W-1:0] free_cnt;
   } alloc_rsp_t;

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   logic [CMD_W-1:0]  req_command;
   logic [SEC_W-1:0]  req_section;
   logic [ADDR_W-1:0] req_slot_address;
   logic [LEN_W-1:0]  req_run_length;
   logic [ID_W-1:0]   req_owner_id;
   logic [TAG_W-1:0]  req_tag;
   logic              req_charge;
   logic rsp_valid, rsp_ready;
   logic [STAT_W-1:0] rsp_status;
   logic [ADDR_W-1:0] rsp_found_address;
   logic [ID_W-1:0]   rsp_found_owner;
   logic [TAG_W-1:0]  rsp_found_tag;
   logic [CNT_W-1:0]  rsp_owned_count;
   logic [SIZE_W-1:0] rsp_free_count;
   logic csr_valid, csr_ready;
   logic [SEC_W-1:0]  csr_index;
   logic [SIZE_W-1:0] csr_wdata;

   first_fit_slot_allocator_top DUT (.*);

   // Shadow of the allocator state.
   logic [ID_W-1:0]   map_owner [TOTAL];
   logic [TAG_W-1:0]  map_tag [TOTAL];
   int                sec_free [NUM_SECTIONS];
   logic [SIZE_W-1:0] size_reg [NUM_SECTIONS];

   alloc_req_t pending_reqs[$];
   alloc_rsp_t expected_rsps[$];
   alloc_req_t cur_req;
   int req_gap, rsp_stall, cycles, errors, n_rsp, n_alloc_ok, n_phases;
   bit quiet;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic int usable(int s);
      return (size_reg[s] > SLOTS_PER_SECTION) ? SLOTS_PER_SECTION : int'(size_reg[s]);
   endfunction

   function automatic void clear_shadow();
      for (int i = 0; i < TOTAL; i++) begin
         map_owner[i] = '0;
         map_tag[i] = '0;
      end
      for (int s = 0; s < NUM_SECTIONS; s++) sec_free[s] = usable(s);
   endfunction

   function automatic alloc_rsp_t predict_response(alloc_req_t r);
      alloc_rsp_t e;
      int size, base, a, n, s, i;
      bit got;
      logic [ID_W-1:0] first;
      e = '{ST_OK, '0, '0, '0, '0, '0};
      size = usable(r.sec);
      base = int'(r.sec) * SLOTS_PER_SECTION;
      a = int'(r.addr);
      n = int'(r.len);
      if (r.cmd == CMD_CLEAR) begin
         clear_shadow();
      end else if (r.cmd > CMD_QUERY || n == 0 || n > MAX_RUN) begin
         e.status = ST_BADADDR;
      end else if (r.cmd == CMD_ALLOC) begin
         if (r.owner == 0) e.status = ST_BADADDR;
         else if (sec_free[r.sec] < n || size < n) e.status = ST_NOSPACE;
         else begin
            got = 0;
            for (s = 0; s + n <= size && !got; s++) begin
               for (i = 0; i < n; i++)
                  if (map_owner[base + s + i] != 0) break;
               if (i == n) begin
                  got = 1;
                  e.addr = ADDR_W'(s);
               end
            end
            if (!got) e.status = ST_NOSPACE;
            else begin
               for (i = 0; i < n; i++) begin
                  map_owner[base + e.addr + i] = r.owner;
                  map_tag[base + e.addr + i] = r.tag;
               end
               sec_free[r.sec] -= n;
               n_alloc_ok++;
            end
         end
      end else if (r.cmd == CMD_FREE) begin
         if (a + n > size) e.status = ST_BADADDR;
         else begin
            first = map_owner[base + a];
            for (i = 1; i < n; i++)
               if (map_owner[base + a + i] != first) break;
            if (i < n) e.status = ST_MIXED;
            else begin
               for (i = 0; i < n; i++) map_owner[base + a + i] = '0;
               sec_free[r.sec] += n;
               if (sec_free[r.sec] > size) sec_free[r.sec] = size;
            end
         end
      end else if (r.cmd == CMD_MARK) begin
         if (a + n > size) e.status = ST_BADADDR;
         else begin
            for (i = 0; i < n; i++) begin
               map_owner[base + a + i] = r.owner;
               map_tag[base + a + i] = r.tag;
            end
            if (r.charge)
               sec_free[r.sec] = (sec_free[r.sec] > n) ? sec_free[r.sec] - n : 0;
         end
      end else begin
         if (a >= size) e.status = ST_BADADDR;
         else begin
            for (i = 0; i < n && a + i < size; i++) begin
               if (map_owner[base + a + i] != 0) begin
                  if (e.owner == 0) begin
                     e.owner = map_owner[base + a + i];
                     e.tag = map_tag[base + a + i];
                  end
                  e.owned++;
               end
            end
         end
      end
      e.free_cnt = SIZE_W'(sec_free[r.sec]);
      return e;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (quiet || p < 50) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(predict_response(cur_req));
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_command <= cur_req.cmd;
               req_section <= cur_req.sec;
               req_slot_address <= cur_req.addr;
               req_run_length <= cur_req.len;
               req_owner_id <= cur_req.owner;
               req_tag <= cur_req.tag;
               req_charge <= cur_req.charge;
               req_valid <= 1'b1;
               req_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      alloc_rsp_t e;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_rsp++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_status);
                  errors++;
               end
               if (rsp_found_address !== e.addr) begin
                  $error("found_address expected %0d actual %0d", e.addr, rsp_found_address);
                  errors++;
               end
               if (rsp_found_owner !== e.owner) begin
                  $error("found_owner expected %0h actual %0h", e.owner, rsp_found_owner);
                  errors++;
               end
               if (rsp_found_tag !== e.tag) begin
                  $error("found_tag expected %0h actual %0h", e.tag, rsp_found_tag);
                  errors++;
               end
               if (rsp_owned_count !== e.owned) begin
                  $error("owned_count expected %0d actual %0d", e.owned, rsp_owned_count);
                  errors++;
               end
               if (rsp_free_count !== e.free_cnt) begin
                  $error("free_count expected %0d actual %0d", e.free_cnt, rsp_free_count);
                  errors++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send(input logic [CMD_W-1:0] c, input int s, input int a, input int n,
                       input int o, input int t, input bit ch);
      alloc_req_t r;
      r.cmd = c;
      r.sec = SEC_W'(s);
      r.addr = ADDR_W'(a);
      r.len = LEN_W'(n);
      r.owner = ID_W'(o);
      r.tag = TAG_W'(t);
      r.charge = ch;
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
      @(posedge clock);
   endtask

   task automatic write_size(input int idx, input int val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= SEC_W'(idx);
      csr_wdata <= SIZE_W'(val);
      do @(posedge clock); while (!csr_ready);
      size_reg[idx] = SIZE_W'(val);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      int p, s, sz, n, a, o;
      logic [CMD_W-1:0] c;
      p = $urandom_range(0, 99);
      if (p < 35) c = CMD_ALLOC;
      else if (p < 55) c = CMD_FREE;
      else if (p < 70) c = CMD_MARK;
      else if (p < 95) c = CMD_QUERY;
      else if (p < 96) c = CMD_CLEAR;
      else c = CMD_W'($urandom_range(5, 7));
      s = $urandom_range(0, NUM_SECTIONS - 1);
      sz = usable(s);
      n = ($urandom_range(0, 99) < 5) ? $urandom_range(0, 15) : $urandom_range(1, MAX_RUN);
      if (sz > 0 && $urandom_range(0, 9) != 0) a = $urandom_range(0, sz - 1);
      else a = $urandom_range(0, 4095);
      // A small owner pool makes runs of one owner common, so frees succeed.
      p = $urandom_range(0, 99);
      if (p < 80) o = $urandom_range(1, 6);
      else if (p < 92) o = $urandom_range(1, 65535);
      else o = 0;
      send(c, s, a, n, o, $urandom_range(0, 65535), $urandom_range(0, 1));
   endtask

   initial begin
      int sizes [NUM_SECTIONS];
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_command = '0;
      req_section = '0;
      req_slot_address = '0;
      req_run_length = '0;
      req_owner_id = '0;
      req_tag = '0;
      req_charge = 1'b0;
      rsp_ready = 1'b0;
      for (int s = 0; s < NUM_SECTIONS; s++) size_reg[s] = SLOTS_PER_SECTION;
      clear_shadow();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed checks at full section size.
      send(CMD_ALLOC, 0, 0, 1, 16'hffff, 16'hffff, 0);
      send(CMD_ALLOC, 0, 0, 8, 16'h0002, 16'h00a5, 0);
      send(CMD_ALLOC, 3, 0, 8, 16'h8000, 16'h5a5a, 0);
      send(CMD_QUERY, 0, 0, 8, 0, 0, 0);
      send(CMD_FREE, 0, 0, 8, 0, 0, 0);
      send(CMD_FREE, 0, 4088, 8, 0, 0, 0);
      send(CMD_FREE, 0, 4089, 8, 0, 0, 0);
      send(CMD_MARK, 0, 4095, 1, 16'h1234, 16'hffff, 1);
      send(CMD_QUERY, 0, 4095, 8, 0, 0, 0);
      send(CMD_MARK, 1, 4090, 6, 0, 16'h0001, 0);
      send(CMD_MARK, 1, 4091, 6, 16'h0003, 16'h0001, 0);
      send(CMD_QUERY, 1, 4095, 1, 0, 0, 0);
      send(CMD_ALLOC, 2, 0, 4, 0, 0, 0);
      send(CMD_UNUSED_5, 0, 0, 1, 1, 0, 0);
      send(CMD_UNUSED_6, 1, 0, 1, 1, 0, 0);
      send(CMD_UNUSED_7, 2, 0, 1, 1, 0, 0);
      send(CMD_QUERY, 0, 0, 0, 0, 0, 0);
      send(CMD_ALLOC, 0, 0, 9, 1, 0, 0);
      send(CMD_MARK, 0, 0, 15, 1, 0, 1);
      send(CMD_CLEAR, 0, 0, 1, 0, 0, 0);
      drain();

      // Empty, oversized and tiny sections.
      write_size(0, 0);
      write_size(1, 8191);
      write_size(2, 16);
      write_size(3, 20);
      send(CMD_CLEAR, 0, 0, 1, 0, 0, 0);
      send(CMD_ALLOC, 0, 0, 1, 1, 1, 0);
      send(CMD_QUERY, 0, 0, 1, 0, 0, 0);
      send(CMD_ALLOC, 2, 0, 8, 1, 7, 0);
      send(CMD_ALLOC, 2, 0, 8, 2, 8, 0);
      send(CMD_ALLOC, 2, 0, 8, 3, 9, 0);
      send(CMD_FREE, 2, 8, 8, 0, 0, 0);
      send(CMD_ALLOC, 2, 0, 8, 3, 9, 0);
      send(CMD_MARK, 3, 0, 8, 4, 4, 1);
      send(CMD_MARK, 3, 8, 8, 4, 4, 1);
      send(CMD_MARK, 3, 12, 8, 4, 4, 1);
      send(CMD_FREE, 3, 12, 8, 0, 0, 0);
      send(CMD_FREE, 3, 13, 8, 0, 0, 0);
      send(CMD_ALLOC, 1, 0, 8, 9, 9, 0);
      drain();

      // Random phases, each under its own section sizes.
      for (int ph = 0; ph < 8; ph++) begin
         quiet = (ph % 4 == 3);
         for (int s = 0; s < NUM_SECTIONS; s++) begin
            case ($urandom_range(0, 9))
               0: sizes[s] = 0;
               1: sizes[s] = SLOTS_PER_SECTION;
               2: sizes[s] = $urandom_range(4097, 8191);
               3: sizes[s] = $urandom_range(65, 300);
               default: sizes[s] = $urandom_range(8, 64);
            endcase
            write_size(s, sizes[s]);
         end
         send(CMD_CLEAR, 0, 0, 1, 0, 0, 0);
         for (int k = 0; k < 115; k++) random_item();
         drain();
         n_phases++;
      end

      repeat (30) @(posedge clock);
      $display("Covered %0d responses over %0d random phases, %0d successful allocations.",
               n_rsp, n_phases, n_alloc_ok);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
